// ----- src/dop_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_pkg: shared types and constants of the dhcp options parser
// option codes, magic cookie bytes, parse phases and the message summary
// ----------------------------------------------------------------------------
package dop_pkg;

	// number of dns addresses kept per message
	localparam int MAX_DNS = 4;
	localparam int IDX_W   = (MAX_DNS > 1) ? $clog2(MAX_DNS) : 1;
	localparam int CNT_W   = ($clog2(MAX_DNS + 1) > 3) ? $clog2(MAX_DNS + 1) : 3;
	localparam logic [7:0] DNS_MAX8 = 8'(MAX_DNS);

	// magic cookie
	localparam logic [7:0] COOKIE_0 = 8'd99;
	localparam logic [7:0] COOKIE_1 = 8'd130;
	localparam logic [7:0] COOKIE_2 = 8'd83;
	localparam logic [7:0] COOKIE_3 = 8'd99;

	// option codes
	localparam logic [7:0] OPT_PAD      = 8'd0;
	localparam logic [7:0] OPT_MASK     = 8'd1;
	localparam logic [7:0] OPT_ROUTER   = 8'd3;
	localparam logic [7:0] OPT_DNS      = 8'd6;
	localparam logic [7:0] OPT_LEASE    = 8'd51;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] OPT_SERVER   = 8'd54;
	localparam logic [7:0] OPT_END      = 8'd255;

	// option lengths that are accepted
	localparam logic [7:0] OPT_ADDR_LEN = 8'd4;
	localparam logic [7:0] OPT_TYPE_LEN = 8'd1;

	// result item kinds
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_DNS     = 1'b1;

	typedef enum logic [1:0] {
		PH_COOKIE,
		PH_CODE,
		PH_LEN,
		PH_VALUE
	} dop_phase_t;

	typedef struct packed {
		logic                         cookie_ok;
		logic [7:0]                   message_type;
		logic [31:0]                  server_ident;
		logic [31:0]                  subnet_mask;
		logic [31:0]                  gateway;
		logic [31:0]                  lease_seconds;
		logic [CNT_W-1:0]             dns_count;
		logic                         dns_overflow;
		logic [MAX_DNS-1:0][31:0]     dns_list;
	} dop_summary_t;

	function automatic logic [7:0] cookie_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0: b = COOKIE_0;
			2'd1: b = COOKIE_1;
			2'd2: b = COOKIE_2;
			default: b = COOKIE_3;
		endcase
		return b;
	endfunction

endpackage

// ----- src/dop_byte_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_byte_if: option byte channel
// valid/ready handshake carrying one byte of the options area per item
// ----------------------------------------------------------------------------
interface dop_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] opt_byte;
	logic       last_byte;

	modport source (output valid, output opt_byte, output last_byte, input ready);
	modport sink   (input valid, input opt_byte, input last_byte, output ready);
endinterface

// ----- src/dop_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_result_if: parse result channel
// valid/ready handshake carrying one summary or dns address item
// ----------------------------------------------------------------------------
interface dop_result_if;
	logic        valid;
	logic        ready;
	logic        item_kind;
	logic        cookie_ok;
	logic [7:0]  message_type;
	logic [31:0] server_ident;
	logic [31:0] subnet_mask;
	logic [31:0] gateway;
	logic [31:0] lease_seconds;
	logic [2:0]  dns_kept;
	logic        dns_dropped;
	logic [31:0] dns_address;
	logic        final_item;

	modport source (
		output valid, output item_kind, output cookie_ok, output message_type,
		output server_ident, output subnet_mask, output gateway, output lease_seconds,
		output dns_kept, output dns_dropped, output dns_address, output final_item,
		input ready
	);
	modport sink (
		input valid, input item_kind, input cookie_ok, input message_type,
		input server_ident, input subnet_mask, input gateway, input lease_seconds,
		input dns_kept, input dns_dropped, input dns_address, input final_item,
		output ready
	);
endinterface

// ----- src/dop_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_parse: per-byte option parser
// cookie check and code/length/value walk; commits complete options
// ----------------------------------------------------------------------------
module dop_parse
	import dop_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   opt_byte,
	input  logic         last_byte,
	output dop_summary_t summary
);

	logic [1:0]               pos_q, pos_d;
	logic                     cookie_q, cookie_d;
	dop_phase_t               phase_q, phase_d;
	logic                     stop_q, stop_d;
	logic [7:0]               code_q, code_d;
	logic [7:0]               dlen_q, dlen_d;
	logic [7:0]               left_q, left_d;
	logic [31:0]              shift_q, shift_d;
	logic [MAX_DNS-1:0][31:0] pend_q, pend_d;
	logic [MAX_DNS-1:0][31:0] comm_q, comm_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic                     ovf_q, ovf_d;
	logic [31:0]              server_q, server_d;
	logic [31:0]              mask_q, mask_d;
	logic [31:0]              router_q, router_d;
	logic [31:0]              lease_q, lease_d;
	logic [7:0]               type_q, type_d;
	logic                     tfound_q, tfound_d;

	logic [7:0] off;
	logic [7:0] dns_cnt;

	assign off     = dlen_q - left_q;
	assign dns_cnt = {2'b00, dlen_q[7:2]};

	always_comb begin
		pos_d    = pos_q;
		cookie_d = cookie_q;
		phase_d  = phase_q;
		stop_d   = stop_q;
		code_d   = code_q;
		dlen_d   = dlen_q;
		left_d   = left_q;
		shift_d  = shift_q;
		pend_d   = pend_q;
		comm_d   = comm_q;
		cnt_d    = cnt_q;
		ovf_d    = ovf_q;
		server_d = server_q;
		mask_d   = mask_q;
		router_d = router_q;
		lease_d  = lease_q;
		type_d   = type_q;
		tfound_d = tfound_q;

		if (!stop_q) begin
			case (phase_q)
				PH_COOKIE: begin
					if (opt_byte != cookie_byte(pos_q)) begin
						stop_d = 1'b1;
					end else if (pos_q == 2'd3) begin
						cookie_d = 1'b1;
						phase_d  = PH_CODE;
					end else begin
						pos_d = pos_q + 2'd1;
					end
				end
				PH_CODE: begin
					if (opt_byte == OPT_END) begin
						stop_d = 1'b1;
					end else if (opt_byte != OPT_PAD) begin
						code_d  = opt_byte;
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					dlen_d  = opt_byte;
					left_d  = opt_byte;
					shift_d = '0;
					phase_d = (opt_byte == 8'd0) ? PH_CODE : PH_VALUE;
				end
				PH_VALUE: begin
					if (off < OPT_ADDR_LEN || code_q == OPT_DNS) begin
						shift_d = {shift_q[23:0], opt_byte};
					end
					// a dns address completes on every fourth value byte
					if (code_q == OPT_DNS && off[1:0] == 2'd3) begin
						for (int k = 0; k < MAX_DNS; k++) begin
							if (off[7:2] == 6'(k)) begin
								pend_d[k] = shift_d;
							end
						end
					end
					left_d = left_q - 8'd1;
					if (left_d == 8'd0) begin
						phase_d = PH_CODE;
						case (code_q)
							OPT_SERVER: begin
								if (dlen_q == OPT_ADDR_LEN) server_d = shift_d;
							end
							OPT_MASK: begin
								if (dlen_q == OPT_ADDR_LEN) mask_d = shift_d;
							end
							OPT_ROUTER: begin
								if (dlen_q >= OPT_ADDR_LEN) router_d = shift_d;
							end
							OPT_LEASE: begin
								if (dlen_q == OPT_ADDR_LEN) lease_d = shift_d;
							end
							OPT_MSG_TYPE: begin
								if (dlen_q == OPT_TYPE_LEN && !tfound_q) begin
									type_d   = shift_d[7:0];
									tfound_d = 1'b1;
								end
							end
							OPT_DNS: begin
								if (dlen_q >= OPT_ADDR_LEN) begin
									comm_d = pend_d;
									cnt_d  = (dns_cnt < DNS_MAX8) ? CNT_W'(dns_cnt)
									                              : CNT_W'(MAX_DNS);
									ovf_d  = dns_cnt > DNS_MAX8;
								end
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		summary.cookie_ok     = cookie_d;
		summary.message_type  = type_d;
		summary.server_ident  = server_d;
		summary.subnet_mask   = mask_d;
		summary.gateway       = router_d;
		summary.lease_seconds = lease_d;
		summary.dns_count     = cnt_d;
		summary.dns_overflow  = ovf_d;
		summary.dns_list      = comm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			cookie_q <= 1'b0;
			phase_q  <= PH_COOKIE;
			stop_q   <= 1'b0;
			code_q   <= '0;
			dlen_q   <= '0;
			left_q   <= '0;
			shift_q  <= '0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			server_q <= '0;
			mask_q   <= '0;
			router_q <= '0;
			lease_q  <= '0;
			type_q   <= '0;
			tfound_q <= 1'b0;
		end else if (take) begin
			if (last_byte) begin
				pos_q    <= '0;
				cookie_q <= 1'b0;
				phase_q  <= PH_COOKIE;
				stop_q   <= 1'b0;
				code_q   <= '0;
				dlen_q   <= '0;
				left_q   <= '0;
				shift_q  <= '0;
				cnt_q    <= '0;
				ovf_q    <= 1'b0;
				server_q <= '0;
				mask_q   <= '0;
				router_q <= '0;
				lease_q  <= '0;
				type_q   <= '0;
				tfound_q <= 1'b0;
			end else begin
				pos_q    <= pos_d;
				cookie_q <= cookie_d;
				phase_q  <= phase_d;
				stop_q   <= stop_d;
				code_q   <= code_d;
				dlen_q   <= dlen_d;
				left_q   <= left_d;
				shift_q  <= shift_d;
				cnt_q    <= cnt_d;
				ovf_q    <= ovf_d;
				server_q <= server_d;
				mask_q   <= mask_d;
				router_q <= router_d;
				lease_q  <= lease_d;
				type_q   <= type_d;
				tfound_q <= tfound_d;
			end
		end
	end

	// address lists hold data only, read back under the count
	always_ff @(posedge clk) begin
		if (take && !last_byte) begin
			pend_q <= pend_d;
			comm_q <= comm_d;
		end
	end

endmodule

// ----- src/dop_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dop_emit: result sequencer
// holds a message summary and sends the summary item then one per address
// ----------------------------------------------------------------------------
module dop_emit
	import dop_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  dop_summary_t        summary,
	output logic                free,
	dop_result_if.source        result_ch
);

	dop_summary_t     snap_q;
	logic             busy_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] dns_sel;
	logic             is_final;
	logic             done;

	assign dns_sel  = idx_q - CNT_W'(1);
	assign is_final = (idx_q == snap_q.dns_count);
	assign done     = busy_q && result_ch.ready && is_final;
	assign free     = !busy_q || done;

	assign result_ch.valid         = busy_q;
	assign result_ch.item_kind     = (idx_q == '0) ? KIND_SUMMARY : KIND_DNS;
	assign result_ch.cookie_ok     = snap_q.cookie_ok;
	assign result_ch.message_type  = snap_q.message_type;
	assign result_ch.server_ident  = snap_q.server_ident;
	assign result_ch.subnet_mask   = snap_q.subnet_mask;
	assign result_ch.gateway       = snap_q.gateway;
	assign result_ch.lease_seconds = snap_q.lease_seconds;
	assign result_ch.dns_kept      = snap_q.dns_count[2:0];
	assign result_ch.dns_dropped   = snap_q.dns_overflow;
	assign result_ch.dns_address   = (idx_q == '0) ? 32'd0
	                                               : snap_q.dns_list[dns_sel[IDX_W-1:0]];
	assign result_ch.final_item    = is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && result_ch.ready) begin
			if (is_final) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			snap_q <= summary;
		end
	end

endmodule

// ----- src/dhcp_option_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_option_parser: dhcp options area parser
// walks cookie and options byte by byte and reports the extracted values
// ----------------------------------------------------------------------------
// byte_ch takes the options area one byte per item, cookie first, with
// last_byte set on the final byte. result_ch gives, for each message, one
// summary item and then one item per kept dns address; final_item marks
// the last of them.
// non-final option bytes are never held back, so they stream at one item
// per cycle. the final byte loads the summary register; the summary item
// shows on result_ch the cycle after, and the address items follow at one
// per cycle while result_ch is ready, so a message gives 1 + dns_kept
// result items, all through the single result port.
// the parser is free for the next message as soon as the final byte is
// taken, but a second final byte waits until the previous message's last
// result item leaves (byte_ch.ready drops for a final byte while results
// are pending).
// when result_ch stalls, the pending item is held steady in the result
// register; non-final bytes of the next message keep flowing and only its
// final byte waits.
// reset clears the parser to expect the cookie and drops any pending items.
// ----------------------------------------------------------------------------
module dhcp_option_parser
	import dop_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	dop_byte_if.sink      byte_ch,
	dop_result_if.source  result_ch
);

	dop_summary_t summary;
	logic         emit_free;
	logic         take;

	// non-final bytes always go in; a final byte needs a free result register
	assign byte_ch.ready = emit_free || !byte_ch.last_byte;
	assign take          = byte_ch.valid && byte_ch.ready;

	// parse state and option commit
	dop_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.opt_byte  (byte_ch.opt_byte),
		.last_byte (byte_ch.last_byte),
		.summary   (summary)
	);

	// summary capture on the final byte and item sequencing
	dop_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && byte_ch.last_byte),
		.summary   (summary),
		.free      (emit_free),
		.result_ch (result_ch)
	);

endmodule

// ----- test/dhcp_option_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhcp_option_parser_tb: self-checking bench for the dhcp options parser
// streams options areas byte by byte and checks each summary and dns
// address item against an in-bench model of the option walk
// ----------------------------------------------------------------------------
module dhcp_option_parser_tb
	import dop_pkg::*;
();

	// run shape
	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_BYTES   = 420;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AT_MSG    = 3;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [7:0] COOKIE_SEQ [4] = '{COOKIE_0, COOKIE_1, COOKIE_2, COOKIE_3};

	// one result item as it should appear on result_ch
	typedef struct {
		logic        item_kind;
		logic        cookie_ok;
		logic [7:0]  message_type;
		logic [31:0] server_ident;
		logic [31:0] subnet_mask;
		logic [31:0] gateway;
		logic [31:0] lease_seconds;
		logic [2:0]  dns_kept;
		logic        dns_dropped;
		logic [31:0] dns_address;
		logic        final_item;
	} lease_report_t;

	// directed stimulus row; typed rows carry a summary with every value zero but cookie_ok, which the row gives
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         typed;
		logic       cookie_ok;
	} byte_row_t;

	logic clk = 1'b0;
	logic arst_n;

	dop_byte_if   byte_ch ();
	dop_result_if result_ch ();

	dhcp_option_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// parser model state, kept in step with every accepted byte
	// ------------------------------------------------------------------------
	int          cookie_pos;
	logic        cookie_seen;
	dop_phase_t  phase;
	logic        walk_stopped;
	logic [7:0]  cur_code;
	logic [7:0]  decl_len;
	logic [7:0]  len_left;
	logic [31:0] value_acc;
	logic [31:0] dns_staged [MAX_DNS];
	logic [31:0] dns_held [MAX_DNS];
	int          dns_count;
	logic        dns_over;
	logic [31:0] server_val, mask_val, router_val, lease_val;
	logic [7:0]  type_val;
	logic        type_seen;

	lease_report_t pending_reports [$];
	logic [7:0]    msg_bytes [$];

	int mismatches  = 0;
	int idle_cycles = 0;
	bit no_gaps     = 1'b0;
	bit hold_flag   = 1'b0;

	// back to "expect cookie" with nothing committed
	function automatic void clear_parse();
		cookie_pos   = 0;
		cookie_seen  = 1'b0;
		phase        = PH_COOKIE;
		walk_stopped = 1'b0;
		cur_code     = '0;
		decl_len     = '0;
		len_left     = '0;
		value_acc    = '0;
		dns_count    = 0;
		dns_over     = 1'b0;
		server_val   = '0;
		mask_val     = '0;
		router_val   = '0;
		lease_val    = '0;
		type_val     = '0;
		type_seen    = 1'b0;
	endfunction

	// an option takes effect only once its last value byte is in
	function automatic void commit_value();
		int groups;
		int kept;
		case (cur_code)
			OPT_SERVER: if (decl_len == OPT_ADDR_LEN) server_val = value_acc;
			OPT_MASK:   if (decl_len == OPT_ADDR_LEN) mask_val = value_acc;
			OPT_ROUTER: if (decl_len >= OPT_ADDR_LEN) router_val = value_acc;
			OPT_LEASE:  if (decl_len == OPT_ADDR_LEN) lease_val = value_acc;
			OPT_MSG_TYPE: begin
				if (decl_len == OPT_TYPE_LEN && !type_seen) begin
					type_val  = value_acc[7:0];
					type_seen = 1'b1;
				end
			end
			OPT_DNS: begin
				// shorter than one address leaves the earlier list alone
				if (decl_len >= OPT_ADDR_LEN) begin
					groups = int'(decl_len) >> 2;
					kept   = (groups < MAX_DNS) ? groups : MAX_DNS;
					for (int k = 0; k < kept; k++)
						dns_held[k] = dns_staged[k];
					dns_count = kept;
					dns_over  = (groups > MAX_DNS);
				end
			end
			default: ;
		endcase
	endfunction

	// walk one byte; on the final byte append the message's items to made
	function automatic void parse_option_byte(input logic [7:0] b, input logic last,
			ref lease_report_t made [$]);
		int offset;
		lease_report_t item;
		if (!walk_stopped) begin
			case (phase)
				PH_COOKIE: begin
					if (b != COOKIE_SEQ[cookie_pos]) begin
						walk_stopped = 1'b1;
					end else if (cookie_pos == 3) begin
						cookie_seen = 1'b1;
						phase       = PH_CODE;
					end else begin
						cookie_pos++;
					end
				end
				PH_CODE: begin
					if (b == OPT_END) begin
						walk_stopped = 1'b1;
					end else if (b != OPT_PAD) begin
						cur_code = b;
						phase    = PH_LEN;
					end
				end
				PH_LEN: begin
					decl_len  = b;
					len_left  = b;
					value_acc = '0;
					if (b == 8'd0) phase = PH_CODE;
					else phase = PH_VALUE;
				end
				default: begin
					offset = int'(decl_len) - int'(len_left);
					// only the first four bytes count, except for the dns list
					if (offset < 4 || cur_code == OPT_DNS)
						value_acc = {value_acc[23:0], b};
					if (cur_code == OPT_DNS && (offset % 4) == 3 && (offset / 4) < MAX_DNS)
						dns_staged[offset / 4] = value_acc;
					len_left = len_left - 8'd1;
					if (len_left == 8'd0) begin
						commit_value();
						phase = PH_CODE;
					end
				end
			endcase
		end
		if (last) begin
			item.item_kind     = KIND_SUMMARY;
			item.cookie_ok     = cookie_seen;
			item.message_type  = type_val;
			item.server_ident  = server_val;
			item.subnet_mask   = mask_val;
			item.gateway       = router_val;
			item.lease_seconds = lease_val;
			item.dns_kept      = 3'(dns_count);
			item.dns_dropped   = dns_over;
			item.dns_address   = '0;
			item.final_item    = (dns_count == 0);
			made.push_back(item);
			// address items repeat the summary values
			for (int k = 0; k < dns_count; k++) begin
				item.item_kind   = KIND_DNS;
				item.dns_address = dns_held[k];
				item.final_item  = (k + 1 == dns_count);
				made.push_back(item);
			end
			clear_parse();
		end
	endfunction

	// mostly back-to-back, sometimes a few cycles, now and then a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ------------------------------------------------------------------------
	// byte sender: offers one item, waits for the handshake, then predicts
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input logic typed_cookie);
		int gap;
		lease_report_t made [$];
		lease_report_t fixed;
		gap = pick_gap();
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.opt_byte  <= b;
		byte_ch.last_byte <= last;
		do @(posedge clk); while (!byte_ch.ready);
		// model always advances, even when the row carries its own answer
		parse_option_byte(b, last, made);
		if (typed) begin
			fixed               = '{default: '0};
			fixed.item_kind     = KIND_SUMMARY;
			fixed.cookie_ok     = typed_cookie;
			fixed.final_item    = 1'b1;
			pending_reports.push_back(fixed);
		end else begin
			foreach (made[i]) pending_reports.push_back(made[i]);
		end
	endtask

	// one option with random content; wrong lengths now and then
	task automatic add_option();
		int pick;
		int len;
		logic [7:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			msg_bytes.push_back(OPT_PAD);
			return;
		end
		if (pick < 22) code = OPT_DNS;
		else if (pick < 34) code = OPT_SERVER;
		else if (pick < 46) code = OPT_MASK;
		else if (pick < 58) code = OPT_ROUTER;
		else if (pick < 70) code = OPT_LEASE;
		else if (pick < 84) code = OPT_MSG_TYPE;
		else code = 8'($urandom_range(1, 254));
		if ($urandom_range(0, 4) == 0) begin
			len = $urandom_range(0, 9);
		end else begin
			case (code)
				OPT_DNS:      len = 4 * $urandom_range(1, 6);
				OPT_ROUTER:   len = $urandom_range(4, 10);
				OPT_MSG_TYPE: len = int'(OPT_TYPE_LEN);
				OPT_SERVER, OPT_MASK, OPT_LEASE: len = int'(OPT_ADDR_LEN);
				default:      len = $urandom_range(0, 8);
			endcase
		end
		msg_bytes.push_back(code);
		msg_bytes.push_back(8'(len));
		repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// kind 0: noise, kind 1: cookie prefix, short or broken,
	// kinds 2..4: well-formed but cut short, otherwise well-formed
	task automatic build_message(output int kind);
		int n;
		kind = $urandom_range(0, 19);
		msg_bytes.delete();
		if (kind == 0) begin
			repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom_range(0, 255)));
		end else if (kind == 1) begin
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) msg_bytes.push_back(COOKIE_SEQ[i]);
			if (n == 0 || $urandom_range(0, 1) == 1) begin
				msg_bytes.push_back(8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 4))
					msg_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			foreach (COOKIE_SEQ[i]) msg_bytes.push_back(COOKIE_SEQ[i]);
			repeat ($urandom_range(1, 6)) add_option();
			if ($urandom_range(0, 5) == 0) begin
				msg_bytes.push_back(OPT_END);
				repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
			end
			if (kind < 5) begin
				n = $urandom_range(5, msg_bytes.size());
				while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// directed part: short message, bad cookie, end code with trailing byte,
	// then pad, message type at the top value, zero length server id, short
	// dns option and a netmask cut off by the last byte
	// ------------------------------------------------------------------------
	byte_row_t directed_rows [] = '{
		'{COOKIE_0, 1'b0, 1'b0, 1'b0}, '{COOKIE_1, 1'b1, 1'b1, 1'b0},
		'{8'h00, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b1, 1'b1, 1'b0},
		'{COOKIE_0, 1'b0, 1'b0, 1'b0}, '{COOKIE_1, 1'b0, 1'b0, 1'b0},
		'{COOKIE_2, 1'b0, 1'b0, 1'b0}, '{COOKIE_3, 1'b0, 1'b0, 1'b0},
		'{OPT_END, 1'b0, 1'b0, 1'b0}, '{8'hA5, 1'b1, 1'b1, 1'b1},
		'{COOKIE_0, 1'b0, 1'b0, 1'b0}, '{COOKIE_1, 1'b0, 1'b0, 1'b0},
		'{COOKIE_2, 1'b0, 1'b0, 1'b0}, '{COOKIE_3, 1'b0, 1'b0, 1'b0},
		'{OPT_PAD, 1'b0, 1'b0, 1'b0},
		'{OPT_MSG_TYPE, 1'b0, 1'b0, 1'b0}, '{OPT_TYPE_LEN, 1'b0, 1'b0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 1'b0},
		'{OPT_SERVER, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0, 1'b0},
		'{OPT_DNS, 1'b0, 1'b0, 1'b0}, '{8'h03, 1'b0, 1'b0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 1'b0}, '{8'h80, 1'b0, 1'b0, 1'b0}, '{8'h7F, 1'b0, 1'b0, 1'b0},
		'{OPT_MASK, 1'b0, 1'b0, 1'b0}, '{OPT_ADDR_LEN, 1'b0, 1'b0, 1'b0},
		'{8'hFF, 1'b1, 1'b0, 1'b0}
	};

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int kind;
		int counted;
		int msg_idx;
		counted = 0;
		msg_idx = 0;
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.opt_byte  = '0;
		byte_ch.last_byte = 1'b0;
		clear_parse();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_byte(directed_rows[i].data, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].cookie_ok);

		// random messages until enough bytes have gone in
		while (counted < RANDOM_BYTES) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			// long receiver hold-off while the sender keeps offering
			if (msg_idx == HOLD_AT_MSG) hold_flag = 1'b1;
			build_message(kind);
			foreach (msg_bytes[i])
				send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, 1'b0);
			counted += msg_bytes.size();
			msg_idx++;
		end
		byte_ch.valid <= 1'b0;
		no_gaps = 1'b0;

		// wait for every predicted item, then a little longer for strays
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS dhcp_option_parser");
		else
			$display("FAIL dhcp_option_parser");
		$finish;
	end

	// ------------------------------------------------------------------------
	// result receiver: random stalls, runs of ready, and one long hold-off
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_flag) begin
				result_ch.ready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
				hold_flag = 1'b0;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					result_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// result checker: each accepted item against the oldest prediction
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		lease_report_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_reports.size() == 0) begin
				$error("result item with nothing expected");
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("item_kind", 32'(want.item_kind), 32'(result_ch.item_kind));
				check_field("cookie_ok", 32'(want.cookie_ok), 32'(result_ch.cookie_ok));
				check_field("message_type", 32'(want.message_type),
					32'(result_ch.message_type));
				check_field("server_ident", want.server_ident, result_ch.server_ident);
				check_field("subnet_mask", want.subnet_mask, result_ch.subnet_mask);
				check_field("gateway", want.gateway, result_ch.gateway);
				check_field("lease_seconds", want.lease_seconds, result_ch.lease_seconds);
				check_field("dns_kept", 32'(want.dns_kept), 32'(result_ch.dns_kept));
				check_field("dns_dropped", 32'(want.dns_dropped),
					32'(result_ch.dns_dropped));
				check_field("dns_address", want.dns_address, result_ch.dns_address);
				check_field("final_item", 32'(want.final_item), 32'(result_ch.final_item));
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any item moving on either channel
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("FAIL dhcp_option_parser");
			$finish;
		end
	end

endmodule
